@@ rtl/vtpc_pkg.sv @@
// Package for the VLAN tag pop / classify block.
// Holds the controller state enum, command/status structs and header constants.
// No dependencies.
package vtpc_pkg;

  localparam int unsigned HEAD_LEN   = 16;
  localparam int unsigned TAG_OFFSET = 12;
  localparam int unsigned TAG_LEN    = 4;
  localparam int unsigned POS_W      = $clog2(HEAD_LEN);
  localparam int unsigned GATE_W     = 12;

  localparam logic [15:0] TPID_CTAG = 16'h8100;
  localparam logic [15:0] TPID_STAG = 16'h88a8;
  localparam logic [GATE_W-1:0] VID_MASK = 12'hfff;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_FLUSH,
    ST_PASS
  } vtpc_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic store_we;     // write the input byte at the fill position
    logic pos_inc;      // advance the fill position
    logic flush_short;  // frame ended early: flush held bytes untagged
    logic flush_head;   // byte 15 arrived: classify and flush the header
    logic flush_adv;    // move one held byte to the output register
    logic pass_load;    // move the input byte straight to the output register
  } vtpc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pos_at_end;   // fill position is the last header byte
    logic flush_last;   // current flush index is the final one
    logic flush_eof;    // flush ends the frame
    logic out_free;     // output register can take a byte this cycle
  } vtpc_sts_t;

endpackage

@@ rtl/vtpc_datapath.sv @@
// Datapath of the VLAN tag pop block: header store, fill/flush counters,
// tag classification and the output register. Depends on vtpc_pkg.
module vtpc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vtpc_pkg::vtpc_cmd_t cmd_i,
  output vtpc_pkg::vtpc_sts_t sts_o,
  input  logic [7:0]         in_byte_i,
  input  logic               in_eof_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_eof_o,
  output logic [11:0]        out_gate_o,
  output logic               out_run_last_o
);
  import vtpc_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(HEAD_LEN - 1);
  localparam logic [POS_W-1:0] LAST_TAGGED = POS_W'(HEAD_LEN - TAG_LEN - 1);

  logic [7:0]        store_q [HEAD_LEN];
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic [POS_W-1:0]  last_q, last_d;
  logic              feof_q, feof_d;
  logic [GATE_W-1:0] gate_q, gate_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  logic              out_eof_q;
  logic [GATE_W-1:0] out_gate_q;
  logic              out_run_last_q;

  logic [15:0]       tpid;
  logic [GATE_W-1:0] vid;
  logic              tag_hit;
  logic              out_free;
  logic              flush_last;

  // Bytes 12-14 are held already; byte 15 is on the input this cycle.
  assign tpid    = {store_q[TAG_OFFSET], store_q[TAG_OFFSET+1]};
  assign vid     = {store_q[TAG_OFFSET+2][3:0], in_byte_i} & VID_MASK;
  assign tag_hit = (tpid == TPID_CTAG) || (tpid == TPID_STAG);

  assign out_free   = !out_valid_q || out_ready_i;
  assign flush_last = (idx_q == last_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      store_q[pos_q] <= in_byte_i;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    idx_d  = idx_q;
    last_d = last_q;
    feof_d = feof_q;
    gate_d = gate_q;
    if (cmd_i.pos_inc) begin
      pos_d = pos_q + POS_W'(1);
    end
    if (cmd_i.flush_short) begin
      pos_d  = '0;
      idx_d  = '0;
      last_d = pos_q;
      feof_d = 1'b1;
      gate_d = '0;
    end
    if (cmd_i.flush_head) begin
      pos_d  = '0;
      idx_d  = '0;
      last_d = tag_hit ? LAST_TAGGED : LAST_POS;
      feof_d = in_eof_i;
      gate_d = tag_hit ? vid : '0;
    end
    if (cmd_i.flush_adv) begin
      idx_d = idx_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      idx_q  <= '0;
      last_q <= '0;
      feof_q <= 1'b0;
      gate_q <= '0;
    end else begin
      pos_q  <= pos_d;
      idx_q  <= idx_d;
      last_q <= last_d;
      feof_q <= feof_d;
      gate_q <= gate_d;
    end
  end

  // Output register: hold until taken, refill from the store or the input.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.flush_adv || cmd_i.pass_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush_adv) begin
      out_byte_q     <= store_q[idx_q];
      out_eof_q      <= flush_last && feof_q;
      out_gate_q     <= gate_q;
      out_run_last_q <= flush_last;
    end else if (cmd_i.pass_load) begin
      out_byte_q     <= in_byte_i;
      out_eof_q      <= in_eof_i;
      out_gate_q     <= gate_q;
      out_run_last_q <= 1'b1;
    end
  end

  assign sts_o.pos_at_end = (pos_q == LAST_POS);
  assign sts_o.flush_last = flush_last;
  assign sts_o.flush_eof  = feof_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_eof_o      = out_eof_q;
  assign out_gate_o     = out_gate_q;
  assign out_run_last_o = out_run_last_q;

endmodule

@@ rtl/vtpc_ctrl.sv @@
// Controller of the VLAN tag pop block: fill / flush / pass-through sequencing
// and the input handshake. Depends on vtpc_pkg.
module vtpc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_eof_i,
  output logic                in_ready_o,
  input  vtpc_pkg::vtpc_sts_t sts_i,
  output vtpc_pkg::vtpc_cmd_t cmd_o
);
  import vtpc_pkg::*;

  vtpc_state_e state_q, state_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_FILL: begin
        in_ready_o = 1'b1;
        if (accept) begin
          cmd_o.store_we = 1'b1;
          if (sts_i.pos_at_end) begin
            cmd_o.flush_head = 1'b1;
            state_d          = ST_FLUSH;
          end else if (in_eof_i) begin
            cmd_o.flush_short = 1'b1;
            state_d           = ST_FLUSH;
          end else begin
            cmd_o.pos_inc = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush_adv = 1'b1;
          if (sts_i.flush_last) begin
            state_d = sts_i.flush_eof ? ST_FILL : ST_PASS;
          end
        end
      end
      ST_PASS: begin
        in_ready_o = sts_i.out_free;
        if (accept) begin
          cmd_o.pass_load = 1'b1;
          if (in_eof_i) begin
            state_d = ST_FILL;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

endmodule

@@ rtl/vlan_tag_pop_classify_core.sv @@
// Header bytes 0-14 are held; the flush starts after byte 15 (or an early end of
// frame) and emits 12 or 16 bytes (N for a short frame), one per cycle while the
// output register is free, with the input stalled. Pass-through bytes take one
// request per cycle while the output register is free, via the output register.
// Reset (rst_ni low, asynchronous) returns to header fill, gate 0, no output.
//
// Top level of the VLAN tag pop / classify block. Instantiates vtpc_ctrl and
// vtpc_datapath; depends on vtpc_pkg.
module vlan_tag_pop_classify_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: one frame byte per request.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_frame
  // Output stream: one frame byte per request, tag removed.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // out_end_of_frame
  output logic [12:0] m_tuser    // [11:0] gate, [12] run_last
);
  import vtpc_pkg::*;

  vtpc_cmd_t   cmd;
  vtpc_sts_t   sts;
  logic [11:0] out_gate;
  logic        out_run_last;

  // Sequence fill, header flush and pass-through; own the input handshake.
  vtpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_eof_i   (s_tlast),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the header, classify the tag and drive the output register.
  vtpc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_byte_i      (s_tdata),
    .in_eof_i       (s_tlast),
    .out_ready_i    (m_tready),
    .out_valid_o    (m_tvalid),
    .out_byte_o     (m_tdata),
    .out_eof_o      (m_tlast),
    .out_gate_o     (out_gate),
    .out_run_last_o (out_run_last)
  );

  assign m_tuser = {out_run_last, out_gate};

`ifndef NO_ASSERTIONS
  // No new input while the header drains.
  a_no_accept_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush_adv |-> !s_tready)
    else $error("input accepted during header flush");

  // A pass-through load always comes from an accepted input byte.
  a_pass_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pass_load |-> (s_tvalid && s_tready))
    else $error("pass-through load without input request");

  // Only one source loads the output register in a cycle, and only when free.
  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.flush_adv || cmd.pass_load) |-> (!(cmd.flush_adv && cmd.pass_load) && sts.out_free))
    else $error("output register overrun");

  // The end of an output frame always closes the run of its input byte.
  a_eof_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tlast) |-> m_tuser[12])
    else $error("end of frame without run_last");
`endif

endmodule
